[rtl/ctd_pkg.sv]
// Package with the colour codes, event codes and the decode step record for the decoder.
package ctd_pkg;

	// Colour codes, red is the high bit.
	localparam logic [2:0] COL_DARK    = 3'd0;
	localparam logic [2:0] COL_BLUE    = 3'd1;
	localparam logic [2:0] COL_MAGENTA = 3'd5;
	localparam logic [2:0] COL_YELLOW  = 3'd6;
	localparam logic [2:0] COL_WHITE   = 3'd7;

	localparam logic [3:0] DATA_COLOURS     = 4'd5;
	localparam logic [2:0] SYMBOLS_PER_BYTE = 3'd4;

	// Parity check modes; the unused code behaves as no parity.
	localparam logic [1:0] PAR_NONE  = 2'd0;
	localparam logic [1:0] PAR_EVEN  = 2'd1;
	localparam logic [1:0] PAR_ODD   = 2'd2;
	localparam logic [1:0] PAR_RESET = PAR_ODD;

	// Event codes of a result beat.
	localparam logic [1:0] EV_BYTE    = 2'd0;
	localparam logic [1:0] EV_CLOSED  = 2'd1;
	localparam logic [1:0] EV_OVERRUN = 2'd2;

	// Result of one decode step: next state and an optional result beat.
	typedef struct packed {
		logic [2:0] next_colour;
		logic [7:0] next_acc;
		logic [2:0] next_count;
		logic       result_valid;
		logic [1:0] event_kind;
		logic [7:0] data_byte;
		logic       mark_parity;
		logic       parity_error;
	} ctd_step_t;

endpackage

[rtl/ctd_decode.sv]
// Combinational decode of one colour sample against the previous colour and the byte state.
module ctd_decode import ctd_pkg::*; (
	input  logic [2:0] sample,
	input  logic [2:0] prev_colour,
	input  logic [7:0] acc,
	input  logic [2:0] count,
	input  logic [1:0] parity_mode,
	output ctd_step_t  step
);

	logic [2:0] offset;
	logic [2:0] base;
	logic [3:0] diff_raw;
	logic [3:0] diff;
	logic [1:0] pair;
	logic [7:0] shifted;
	logic [2:0] count_inc;
	logic       rx_parity;
	logic       calc_parity;
	logic       check_on;

	// Bit pair from the colour difference, reduced mod 5 and then mod 4.
	always_comb begin
		offset   = (prev_colour >= COL_BLUE && prev_colour <= COL_MAGENTA) ? prev_colour : 3'd0;
		base     = sample - 3'd1;
		diff_raw = {1'b0, base} + DATA_COLOURS - {1'b0, offset};
		diff     = (diff_raw >= DATA_COLOURS) ? diff_raw - DATA_COLOURS : diff_raw;
		pair     = diff[1:0];
		shifted  = {acc[5:0], pair};
		count_inc = count + 3'd1;
	end

	// Parity of the accumulated byte under the selected mode.
	always_comb begin
		rx_parity   = (sample == COL_YELLOW);
		calc_parity = (parity_mode == PAR_EVEN) ? ^acc : ~(^acc);
		check_on    = (parity_mode == PAR_EVEN) || (parity_mode == PAR_ODD);
	end

	// Classify the sample and form the next state and result.
	always_comb begin
		step              = '0;
		step.next_colour  = sample;
		step.next_acc     = acc;
		step.next_count   = count;
		if (sample == prev_colour) begin
			step.next_colour = prev_colour;
		end else if (sample == COL_DARK) begin
			step.next_acc     = '0;
			step.next_count   = '0;
			step.result_valid = 1'b1;
			step.event_kind   = EV_CLOSED;
		end else if (sample == COL_YELLOW || sample == COL_WHITE) begin
			step.next_acc     = '0;
			step.next_count   = '0;
			step.result_valid = 1'b1;
			step.event_kind   = EV_BYTE;
			step.data_byte    = acc;
			step.mark_parity  = rx_parity;
			step.parity_error = check_on && (calc_parity != rx_parity);
		end else if (count_inc > SYMBOLS_PER_BYTE) begin
			step.next_acc     = '0;
			step.next_count   = '0;
			step.result_valid = 1'b1;
			step.event_kind   = EV_OVERRUN;
			step.data_byte    = shifted;
		end else begin
			step.next_acc   = shifted;
			step.next_count = count_inc;
		end
	end

endmodule

[rtl/colour_transition_decoder.sv]
// Top level of the colour transition decoder: input register, decode state and result register.
//
//  Channel   Signals                                          Direction
//  input     in_valid, in_ready, colour_sample                sink
//  result    out_valid, out_ready, event_kind, data_byte,     source
//            mark_parity, parity_error
//  config    cfg_write_en, cfg_write_data                     sink, no wait
//
// One sample per cycle while the output is not stalled: a beat is registered in the input
// register, decoded from there, and its result, if any, lands in the output register.
// The decode stage advances whenever it holds a sample and the output register is empty or being taken.
// Reset clears the previous colour to dark, the byte state and the parity mode to odd.
// A stalled output holds its result while one more sample waits in the input register.
module colour_transition_decoder import ctd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] colour_sample,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_kind,
	output logic [7:0] data_byte,
	output logic       mark_parity,
	output logic       parity_error,
	input  logic       cfg_write_en,
	input  logic [1:0] cfg_write_data
);

	logic       valid_s1;
	logic [2:0] sample_s1;
	logic [1:0] mode_q;
	logic [2:0] prev_q;
	logic [7:0] acc_q;
	logic [2:0] count_q;
	logic       out_valid_q;
	logic [1:0] event_kind_q;
	logic [7:0] data_byte_q;
	logic       mark_parity_q;
	logic       parity_error_q;
	logic       advance;
	ctd_step_t  step;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	ctd_decode u_decode (
		.sample      (sample_s1),
		.prev_colour (prev_q),
		.acc         (acc_q),
		.count       (count_q),
		.parity_mode (mode_q),
		.step        (step)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PAR_RESET;
		end else if (cfg_write_en) begin
			mode_q <= cfg_write_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= colour_sample;
		end
	end

	// Decode state, updated as each sample leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= COL_DARK;
			acc_q   <= '0;
			count_q <= '0;
		end else if (advance) begin
			prev_q  <= step.next_colour;
			acc_q   <= step.next_acc;
			count_q <= step.next_count;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step.result_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance && step.result_valid) begin
			event_kind_q   <= step.event_kind;
			data_byte_q    <= step.data_byte;
			mark_parity_q  <= step.mark_parity;
			parity_error_q <= step.parity_error;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = event_kind_q;
	assign data_byte    = data_byte_q;
	assign mark_parity  = mark_parity_q;
	assign parity_error = parity_error_q;

endmodule
